// ===== rtl/pixel_alpha_over_blend_macros.svh =====
// ----------------------------------------------------------------------------
// pixel_alpha_over_blend_macros
// Assertion macros shared by the alpha blend RTL. They expect clk and rst in
// the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef PIXEL_ALPHA_OVER_BLEND_MACROS_SVH
`define PIXEL_ALPHA_OVER_BLEND_MACROS_SVH

// same-cycle implication, held off during reset
`define PAOB_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define PAOB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/paob_pkg.sv =====
// ----------------------------------------------------------------------------
// paob_pkg
// Types, constants and small arithmetic helpers for the RGBA8 over blend
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package paob_pkg;

  // pipeline depth and channel layout
  localparam int unsigned NSTG     = 9;
  localparam int unsigned NCH      = 3;
  localparam int unsigned CH_A     = 3;
  localparam logic [7:0]  CHAN_MAX = 8'hFF;

  // pixel: [0] red, [1] green, [2] blue, [3] alpha
  typedef logic [3:0][7:0] pix_t;

  // one restoring divide step
  typedef struct packed {
    logic [16:0] rem;
    logic        bit_q;
  } dstep_t;

  // registered inputs
  typedef struct packed {
    pix_t fg;
    pix_t bg;
    logic opq;
  } s1_t;

  // first products
  typedef struct packed {
    logic [NCH-1:0][15:0] fa;
    logic [NCH-1:0][15:0] bb;
    logic [15:0]          bi;
    logic [7:0]           a;
    logic [7:0]           inv;
    logic                 opq;
    logic                 byp;
    pix_t                 pix;
  } s2_t;

  // background term split by 255, output alpha
  typedef struct packed {
    logic [NCH-1:0][15:0] fa;
    logic [NCH-1:0][7:0]  m;
    logic [NCH-1:0][7:0]  n;
    logic [7:0]           k;
    logic [7:0]           ao;
    logic                 byp;
    pix_t                 pix;
  } s3_t;

  // scaled background parts
  typedef struct packed {
    logic [NCH-1:0][15:0] fa;
    logic [NCH-1:0][15:0] mi;
    logic [NCH-1:0][15:0] ni;
    logic [7:0]           ao;
    logic                 byp;
    pix_t                 pix;
  } s4_t;

  // divider stages
  typedef struct packed {
    logic [NCH-1:0][16:0] rem;
    logic [NCH-1:0][7:0]  q;
    logic [NCH-1:0]       sat;
    logic [7:0]           ao;
    logic                 byp;
    pix_t                 pix;
  } dv_t;

  // x / 255 by add and shift, exact for x up to 65534
  function automatic logic [8:0] div255(input logic [16:0] x);
    logic [16:0] s;
    s = x + {8'd0, x[16:8]} + 17'd1;
    return s[16:8];
  endfunction

  // compare and subtract against a shifted divisor
  function automatic dstep_t div_step(input logic [16:0] rem, input logic [16:0] dsh);
    dstep_t r;
    if (rem >= dsh) begin
      r.rem   = rem - dsh;
      r.bit_q = 1'b1;
    end else begin
      r.rem   = rem;
      r.bit_q = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pixel_alpha_over_blend.sv =====
// Throughput: one item per clock while out_ready is high; the nine register
// stages with two quotient bits per divider stage set the rate, and each
// stage stalls on its own. Reset clears all stage valid bits and
// background_opaque; cfg_ready is always high and no clearing pass is needed.
// ----------------------------------------------------------------------------
// pixel_alpha_over_blend
// RGBA8 over compositing: pass-through for transparent or opaque foreground,
// linear mix against an opaque background, otherwise the integer over rule
// with a pipelined restoring divider and saturation to 255.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pixel_alpha_over_blend_macros.svh"

module pixel_alpha_over_blend (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] fg_red,
  input  logic [7:0] fg_green,
  input  logic [7:0] fg_blue,
  input  logic [7:0] fg_alpha,
  input  logic [7:0] bg_red,
  input  logic [7:0] bg_green,
  input  logic [7:0] bg_blue,
  input  logic [7:0] bg_alpha,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha
);
  import paob_pkg::*;

  logic              background_opaque;
  logic [NSTG-1:0]   vld;
  logic [NSTG:0]     adv;
  logic [NSTG-1:0]   vin;
  s1_t               s1;
  s2_t               s2, s2_next;
  s3_t               s3, s3_next;
  s4_t               s4, s4_next;
  dv_t               dv      [0:3];
  dv_t               dv_next [0:3];
  pix_t              opix, opix_next;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      background_opaque <= 1'b0;
    end else if (cfg_valid) begin
      background_opaque <= cfg_data;
    end
  end

  // per-stage advance: a stage takes an item when empty or moving on
  always_comb begin
    adv[NSTG] = out_ready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_ready = adv[0];
  assign vin      = {vld[NSTG-2:0], in_valid};

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (adv[i]) begin
          vld[i] <= vin[i];
        end
      end
    end
  end

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      s1.fg  <= {fg_alpha, fg_blue, fg_green, fg_red};
      s1.bg  <= {bg_alpha, bg_blue, bg_green, bg_red};
      s1.opq <= background_opaque;
    end
  end

  // stage 2: channel products and pass-through select
  always_comb begin
    logic [7:0] mul;
    s2_next.a   = s1.fg[CH_A];
    s2_next.inv = CHAN_MAX - s1.fg[CH_A];
    mul         = s1.opq ? s2_next.inv : s1.bg[CH_A];
    for (int i = 0; i < NCH; i++) begin
      s2_next.fa[i] = 16'(s1.fg[i]) * 16'(s2_next.a);
      s2_next.bb[i] = 16'(s1.bg[i]) * 16'(mul);
    end
    s2_next.bi  = 16'(s1.bg[CH_A]) * 16'(s2_next.inv);
    s2_next.opq = s1.opq;
    s2_next.byp = (s2_next.a == 8'h00) || (s2_next.a == CHAN_MAX);
    s2_next.pix = (s2_next.a == 8'h00) ? s1.bg : s1.fg;
  end

  always_ff @(posedge clk) begin
    if (adv[1] && vld[0]) begin
      s2 <= s2_next;
    end
  end

  // stage 3: split background term as 255*m + n, form output alpha
  always_comb begin
    logic [8:0] mq;
    logic [8:0] aq;
    mq = '0;
    for (int i = 0; i < NCH; i++) begin
      mq            = div255({1'b0, s2.bb[i]});
      s3_next.m[i]  = mq[7:0];
      s3_next.n[i]  = 8'(s2.bb[i] - ({mq[7:0], 8'h00} - {8'h00, mq[7:0]}));
    end
    aq          = div255({1'b0, s2.bi});
    s3_next.fa  = s2.fa;
    // opaque mode scales by 255 so the background term comes back unchanged
    s3_next.k   = s2.opq ? CHAN_MAX : s2.inv;
    s3_next.ao  = s2.opq ? CHAN_MAX : s2.a + aq[7:0];
    s3_next.byp = s2.byp;
    s3_next.pix = s2.pix;
  end

  always_ff @(posedge clk) begin
    if (adv[2] && vld[1]) begin
      s3 <= s3_next;
    end
  end

  // stage 4: scale both background parts
  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      s4_next.mi[i] = 16'(s3.m[i]) * 16'(s3.k);
      s4_next.ni[i] = 16'(s3.n[i]) * 16'(s3.k);
    end
    s4_next.fa  = s3.fa;
    s4_next.ao  = s3.ao;
    s4_next.byp = s3.byp;
    s4_next.pix = s3.pix;
  end

  always_ff @(posedge clk) begin
    if (adv[3] && vld[2]) begin
      s4 <= s4_next;
    end
  end

  // stages 5 to 8: numerator, then the divider
  always_comb begin
    logic [16:0] num;
    dstep_t      st_hi, st_lo;
    // stage 5: numerator and saturation check
    num = '0;
    for (int i = 0; i < NCH; i++) begin
      num                = 17'(s4.fa[i]) + 17'(s4.mi[i]) + 17'(div255({1'b0, s4.ni[i]}));
      dv_next[0].rem[i]  = num;
      dv_next[0].q[i]    = 8'h00;
      dv_next[0].sat[i]  = num >= {1'b0, s4.ao, 8'h00};
    end
    dv_next[0].ao  = s4.ao;
    dv_next[0].byp = s4.byp;
    dv_next[0].pix = s4.pix;
    // stages 6 to 8: two quotient bits each
    for (int j = 1; j < 4; j++) begin
      dv_next[j] = dv[j-1];
      for (int i = 0; i < NCH; i++) begin
        st_hi = div_step(dv[j-1].rem[i], {9'd0, dv[j-1].ao} << (9 - 2 * j));
        st_lo = div_step(st_hi.rem, {9'd0, dv[j-1].ao} << (8 - 2 * j));
        dv_next[j].q[i][9-2*j] = st_hi.bit_q;
        dv_next[j].q[i][8-2*j] = st_lo.bit_q;
        dv_next[j].rem[i]      = st_lo.rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      if (adv[4+j] && vld[3+j]) begin
        dv[j] <= dv_next[j];
      end
    end
  end

  // stage 9: last quotient bits and result select
  always_comb begin
    dstep_t     st_hi, st_lo;
    logic [7:0] qf;
    qf = '0;
    for (int i = 0; i < NCH; i++) begin
      st_hi        = div_step(dv[3].rem[i], {9'd0, dv[3].ao} << 1);
      st_lo        = div_step(st_hi.rem, {9'd0, dv[3].ao});
      qf           = {dv[3].q[i][7:2], st_hi.bit_q, st_lo.bit_q};
      opix_next[i] = dv[3].byp    ? dv[3].pix[i] :
                     dv[3].sat[i] ? CHAN_MAX     : qf;
    end
    opix_next[CH_A] = dv[3].byp ? dv[3].pix[CH_A] : dv[3].ao;
  end

  always_ff @(posedge clk) begin
    if (adv[8] && vld[7]) begin
      opix <= opix_next;
    end
  end

  // output item
  assign out_valid = vld[8];
  assign out_red   = opix[0];
  assign out_green = opix[1];
  assign out_blue  = opix[2];
  assign out_alpha = opix[CH_A];

  // checks
  `PAOB_ASSERT_IMPLY(a_blocked_only_when_full, !in_ready, (&vld) && !out_ready,
    "input blocked while the pipeline has room")
  `PAOB_ASSERT_IMPLY(a_divisor_nonzero, vld[2] && !s3.byp, s3.ao != 8'h00,
    "blend item reached the divider with zero output alpha")
  `PAOB_ASSERT_IMPLY(a_div_remainder, vld[7] && !dv[3].byp,
    (dv[3].sat[0] || (dv[3].rem[0] < ({9'd0, dv[3].ao} << 2))) &&
    (dv[3].sat[1] || (dv[3].rem[1] < ({9'd0, dv[3].ao} << 2))) &&
    (dv[3].sat[2] || (dv[3].rem[2] < ({9'd0, dv[3].ao} << 2))),
    "divider remainder out of range before the last step")
  `PAOB_ASSERT_NEXT(a_stalled_item_held, vld[4] && !adv[5], vld[4] && $stable(dv[0]),
    "stalled divider item lost or changed")

endmodule

`default_nettype wire
